// File: hdl/stl_pkg.sv
// stl_pkg: shared constants for the sample time lookup block
// widths, status and mode codes, run table depth defaults
// no dependencies
package stl_pkg;

    // table depth defaults
    localparam int TIME_RUNS_DEF   = 256;
    localparam int OFFSET_RUNS_DEF = 256;

    // field widths
    localparam int MODE_W   = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int DTS_W    = 63;
    localparam int PTS_W    = 64;
    localparam int DUR_W    = 52;
    localparam int CFG_IDX_W = 1;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_TS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADD_CO = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMESCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CTTS      = 1'd1;

    localparam logic [WORD_W-1:0] US_PER_SEC = 32'd1000000;

endpackage

// File: hdl/sample_time_lookup_unit.sv
// sample_time_lookup_unit: run table timing lookup, top level
// holds both run tables, walks them and converts ticks to microseconds
// depends on stl_pkg
//
// One transaction is taken at a time; o_ready is high only while idle.
// Clear and append transactions go straight to the output register. A
// query reads, multiplies and accumulates each time run walked, reads
// and compares each offset run walked (when offsets are on), then does
// two or three tick conversions, each two 64-step restoring divisions by
// the timescale on the one shared divider plus three passes through the
// one shared 32x32 multiplier. The result waits in an output register;
// appended runs are stored in on-chip memories with registered read
// data, so no clearing pass exists.
module sample_time_lookup_unit #(
    parameter int TIME_RUNS   = stl_pkg::TIME_RUNS_DEF,
    parameter int OFFSET_RUNS = stl_pkg::OFFSET_RUNS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [stl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [stl_pkg::WORD_W-1:0]         i_cfg_data,
    // input channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [stl_pkg::MODE_W-1:0]         i_mode,
    input  logic [stl_pkg::WORD_W-1:0]         i_run_count,
    input  logic [stl_pkg::WORD_W-1:0]         i_run_delta,
    input  logic signed [stl_pkg::WORD_W-1:0]  i_run_offset,
    input  logic [stl_pkg::WORD_W-1:0]         i_sample_index,
    // result channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [stl_pkg::STATUS_W-1:0]       o_status,
    output logic [stl_pkg::DTS_W-1:0]          o_decode_time_us,
    output logic signed [stl_pkg::PTS_W-1:0]   o_present_time_us,
    output logic [stl_pkg::DUR_W-1:0]          o_duration_us
);
    import stl_pkg::*;

    localparam int TAW   = (TIME_RUNS > 1) ? $clog2(TIME_RUNS) : 1;
    localparam int OAW   = (OFFSET_RUNS > 1) ? $clog2(OFFSET_RUNS) : 1;
    localparam int TCW   = $clog2(TIME_RUNS + 1);
    localparam int OCW   = $clog2(OFFSET_RUNS + 1);
    localparam int CURW  = WORD_W + TCW;
    localparam int OCURW = WORD_W + OCW;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TRD  = 4'd1;
    localparam logic [3:0] S_TMUL = 4'd2;
    localparam logic [3:0] S_TACC = 4'd3;
    localparam logic [3:0] S_ORD  = 4'd4;
    localparam logic [3:0] S_OCMP = 4'd5;
    localparam logic [3:0] S_CVS  = 4'd6;
    localparam logic [3:0] S_DIV1 = 4'd7;
    localparam logic [3:0] S_M1   = 4'd8;
    localparam logic [3:0] S_M2   = 4'd9;
    localparam logic [3:0] S_M3   = 4'd10;
    localparam logic [3:0] S_D2I  = 4'd11;
    localparam logic [3:0] S_DIV2 = 4'd12;
    localparam logic [3:0] S_CVE  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    // conversion selects
    localparam logic [1:0] CV_DTS = 2'd0;
    localparam logic [1:0] CV_DUR = 2'd1;
    localparam logic [1:0] CV_PTS = 2'd2;

    localparam logic [6:0] DIV_STEPS = 7'd64;

    // run memories: count in upper word, delta or offset in lower word
    logic [2*WORD_W-1:0] time_mem [TIME_RUNS];
    logic [2*WORD_W-1:0] ofs_mem  [OFFSET_RUNS];

    logic [3:0]          r_state, n_state;
    logic [WORD_W-1:0]   r_ts;
    logic                r_ctts;
    logic [TCW-1:0]      r_tused;
    logic [OCW-1:0]      r_oused;
    logic [TCW-1:0]      r_ti;
    logic [OCW-1:0]      r_oi;
    logic [2*WORD_W-1:0] r_trd, r_ord;
    logic [WORD_W-1:0]   r_idx;
    logic [CURW-1:0]     r_cursor;
    logic [OCURW-1:0]    r_oc;
    logic [63:0]         r_ticks;
    logic [WORD_W-1:0]   r_dur;
    logic [63:0]         r_off;
    logic                r_hit;
    logic [1:0]          r_cv_sel;
    logic                r_neg;
    logic [63:0]         r_dq;
    logic [WORD_W-1:0]   r_drem;
    logic [6:0]          r_dcnt;
    logic [63:0]         r_prod;
    logic [63:0]         r_acc;
    logic [STATUS_W-1:0] r_status;
    logic [63:0]         r_dts_w, r_pts_w, r_dur_w;
    logic                r_ovalid;
    logic [STATUS_W-1:0] r_o_status;
    logic [DTS_W-1:0]    r_o_dts;
    logic [PTS_W-1:0]    r_o_pts;
    logic [DUR_W-1:0]    r_o_dur;

    logic                w_acc_in;
    logic                w_load_out;
    logic [WORD_W-1:0]   w_tc, w_td, w_oc_cnt;
    logic [CURW-1:0]     w_tend;
    logic [OCURW-1:0]    w_oend;
    logic                w_thit, w_ohit;
    logic                w_tlast, w_olast;
    logic [WORD_W-1:0]   w_mul_a, w_mul_b;
    logic [63:0]         w_prod;
    logic [WORD_W:0]     w_rem_sh;
    logic                w_ge;
    logic [WORD_W:0]     w_rem_sub;
    logic [63:0]         w_cv_in;
    logic [63:0]         w_cv_res;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign w_acc_in    = i_valid && o_ready;
    assign w_load_out  = (r_state == S_DONE) && (!r_ovalid || i_ready);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts   <= '0;
            r_ctts <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TIMESCALE: r_ts   <= i_cfg_data;
                CFG_CTTS:      r_ctts <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // run memories, written on append and read one entry per walk step
    always_ff @(posedge i_clk) begin
        if (w_acc_in && i_mode == MODE_ADD_TS && r_tused != TCW'(TIME_RUNS))
            time_mem[r_tused[TAW-1:0]] <= {i_run_count, i_run_delta};
        r_trd <= time_mem[r_ti[TAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in && i_mode == MODE_ADD_CO && r_oused != OCW'(OFFSET_RUNS))
            ofs_mem[r_oused[OAW-1:0]] <= {i_run_count, i_run_offset};
        r_ord <= ofs_mem[r_oi[OAW-1:0]];
    end

    // walk compares
    assign w_tc     = r_trd[2*WORD_W-1:WORD_W];
    assign w_td     = r_trd[WORD_W-1:0];
    assign w_tend   = r_cursor + CURW'(w_tc);
    assign w_thit   = CURW'(r_idx) < w_tend;
    assign w_tlast  = (r_ti + TCW'(1)) == r_tused;
    assign w_oc_cnt = r_ord[2*WORD_W-1:WORD_W];
    assign w_oend   = r_oc + OCURW'(w_oc_cnt);
    assign w_ohit   = OCURW'(r_idx) < w_oend;
    assign w_olast  = (r_oi + OCW'(1)) == r_oused;

    // shared multiplier operand select
    always_comb begin
        w_mul_a = r_dq[WORD_W-1:0];
        w_mul_b = US_PER_SEC;
        case (r_state)
            S_TMUL: begin
                w_mul_a = w_thit ? (r_idx - r_cursor[WORD_W-1:0]) : w_tc;
                w_mul_b = w_td;
            end
            S_M1:    w_mul_a = r_dq[WORD_W-1:0];
            S_M2:    w_mul_a = r_dq[63:WORD_W];
            S_M3:    w_mul_a = r_drem;
            default: w_mul_a = r_dq[WORD_W-1:0];
        endcase
    end
    assign w_prod = 64'(w_mul_a) * 64'(w_mul_b);

    // shared restoring divider step
    assign w_rem_sh  = {r_drem, r_dq[63]};
    assign w_ge      = w_rem_sh >= {1'b0, r_ts};
    assign w_rem_sub = w_rem_sh - {1'b0, r_ts};

    // conversion operand and final result
    always_comb begin
        case (r_cv_sel)
            CV_DTS:  w_cv_in = r_ticks;
            CV_DUR:  w_cv_in = 64'(r_dur);
            default: w_cv_in = r_ticks + r_off;
        endcase
    end
    always_comb begin
        w_cv_res = r_acc + r_dq;
        if (r_neg)
            w_cv_res = 64'd0 - w_cv_res;
        if (r_ts == '0)
            w_cv_res = '0;
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc_in) begin
                    if (i_mode == MODE_QUERY && r_tused != '0)
                        n_state = S_TRD;
                    else
                        n_state = S_DONE;
                end
            end
            S_TRD:  n_state = S_TMUL;
            S_TMUL: n_state = S_TACC;
            S_TACC: begin
                if (r_hit || w_tlast)
                    n_state = (r_ctts && r_oused != '0) ? S_ORD : S_CVS;
                else
                    n_state = S_TRD;
            end
            S_ORD:  n_state = S_OCMP;
            S_OCMP: n_state = (w_ohit || w_olast) ? S_CVS : S_ORD;
            S_CVS:  n_state = S_DIV1;
            S_DIV1: n_state = (r_dcnt == 7'd1) ? S_M1 : S_DIV1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_D2I;
            S_D2I:  n_state = S_DIV2;
            S_DIV2: n_state = (r_dcnt == 7'd1) ? S_CVE : S_DIV2;
            S_CVE: begin
                if (r_cv_sel == CV_DTS || (r_cv_sel == CV_DUR && r_ctts))
                    n_state = S_CVS;
                else
                    n_state = S_DONE;
            end
            S_DONE:  n_state = w_load_out ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tused  <= '0;
            r_oused  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc_in) begin
                case (i_mode)
                    MODE_CLEAR: begin
                        r_tused <= '0;
                        r_oused <= '0;
                    end
                    MODE_ADD_TS: begin
                        if (r_tused != TCW'(TIME_RUNS))
                            r_tused <= r_tused + TCW'(1);
                    end
                    MODE_ADD_CO: begin
                        if (r_oused != OCW'(OFFSET_RUNS))
                            r_oused <= r_oused + OCW'(1);
                    end
                    default: ;
                endcase
            end
            if (w_load_out)
                r_ovalid <= 1'b1;
            else if (i_ready)
                r_ovalid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx    <= i_sample_index;
                r_ti     <= '0;
                r_oi     <= '0;
                r_cursor <= '0;
                r_oc     <= '0;
                r_ticks  <= '0;
                r_dur    <= '0;
                r_off    <= '0;
                r_hit    <= 1'b0;
                r_cv_sel <= CV_DTS;
                r_dts_w  <= '0;
                r_pts_w  <= '0;
                r_dur_w  <= '0;
                r_status <= ST_OK;
                case (i_mode)
                    MODE_ADD_TS:
                        if (r_tused == TCW'(TIME_RUNS)) r_status <= ST_FULL;
                    MODE_ADD_CO:
                        if (r_oused == OCW'(OFFSET_RUNS)) r_status <= ST_FULL;
                    MODE_QUERY:
                        if (r_tused == '0) r_status <= ST_EMPTY;
                    default: ;
                endcase
            end
            S_TMUL: begin
                r_prod <= w_prod;
                r_hit  <= w_thit;
                if (w_thit)
                    r_dur <= w_td;
                else
                    r_cursor <= w_tend;
            end
            S_TACC: begin
                r_ticks <= r_ticks + r_prod;
                r_ti    <= r_ti + TCW'(1);
            end
            S_OCMP: begin
                r_oc <= w_oend;
                r_oi <= r_oi + OCW'(1);
                if (w_ohit)
                    r_off <= 64'(signed'(r_ord[WORD_W-1:0]));
            end
            S_CVS: begin
                r_neg  <= (r_cv_sel != CV_DUR) && w_cv_in[63];
                r_dq   <= ((r_cv_sel != CV_DUR) && w_cv_in[63]) ? 64'd0 - w_cv_in : w_cv_in;
                r_drem <= '0;
                r_dcnt <= DIV_STEPS;
            end
            S_DIV1, S_DIV2: begin
                r_drem <= w_ge ? w_rem_sub[WORD_W-1:0] : w_rem_sh[WORD_W-1:0];
                r_dq   <= {r_dq[62:0], w_ge};
                r_dcnt <= r_dcnt - 7'd1;
            end
            S_M1: r_prod <= w_prod;
            S_M2: begin
                r_acc  <= r_prod;
                r_prod <= w_prod;
            end
            S_M3: begin
                r_acc  <= r_acc + {r_prod[WORD_W-1:0], 32'd0};
                r_prod <= w_prod;
            end
            S_D2I: begin
                r_dq   <= r_prod;
                r_drem <= '0;
                r_dcnt <= DIV_STEPS;
            end
            S_CVE: begin
                case (r_cv_sel)
                    CV_DTS: begin
                        r_dts_w  <= w_cv_res;
                        r_cv_sel <= CV_DUR;
                    end
                    CV_DUR: begin
                        r_dur_w  <= w_cv_res;
                        r_cv_sel <= CV_PTS;
                        if (!r_ctts)
                            r_pts_w <= r_dts_w;
                    end
                    default: r_pts_w <= w_cv_res;
                endcase
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_status <= r_status;
            r_o_dts    <= r_dts_w[DTS_W-1:0];
            r_o_pts    <= r_pts_w;
            r_o_dur    <= r_dur_w[DUR_W-1:0];
        end
    end

    assign o_valid           = r_ovalid;
    assign o_status          = r_o_status;
    assign o_decode_time_us  = r_o_dts;
    assign o_present_time_us = r_o_pts;
    assign o_duration_us     = r_o_dur;

    // checks
    a_tused_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tused <= TCW'(TIME_RUNS))
        else $error("time run count past depth");

    a_oused_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oused <= OCW'(OFFSET_RUNS))
        else $error("offset run count past depth");

    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV1 || r_state == S_DIV2) |-> r_dcnt != 7'd0)
        else $error("divider ran past its step count");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && r_status != ST_OK) |=> (o_duration_us == '0 && o_decode_time_us == '0))
        else $error("error transaction carries time fields");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRD) |-> r_ti < r_tused)
        else $error("time walk past fill count");
endmodule

// File: verif/testbench.sv
// testbench: self-checking bench for sample_time_lookup_unit
// predicts run table lookups and tick conversions, checks every result
// depends on stl_pkg and sample_time_lookup_unit
module testbench;
    import stl_pkg::*;

    localparam int TABLE_DEPTH = TIME_RUNS_DEF;
    localparam int QUIET_LIMIT = 200000;

    // one predicted result
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DTS_W-1:0]    decode_us;
        logic [PTS_W-1:0]    present_us;
        logic [DUR_W-1:0]    dur_us;
    } t_lookup_result;

    // in-order store of predicted lookup results
    class t_lookup_scoreboard;
        t_lookup_result pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function void note_input(t_lookup_result r);
            pending.push_back(r);
        endfunction

        function void check_result(t_lookup_result got);
            t_lookup_result want;
            if (pending.size() == 0) begin
                $error("result with nothing pending: status %0d", got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.decode_us !== want.decode_us) begin
                $error("decode_time_us expected %0h actual %0h", want.decode_us, got.decode_us);
                errors++;
            end
            if (got.present_us !== want.present_us) begin
                $error("present_time_us expected %0h actual %0h",
                       want.present_us, got.present_us);
                errors++;
            end
            if (got.dur_us !== want.dur_us) begin
                $error("duration expected %0h actual %0h",
                       want.dur_us, got.dur_us);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [WORD_W-1:0]      i_cfg_data;
    logic                   i_valid;
    logic                   o_ready;
    logic [MODE_W-1:0]      i_mode;
    logic [WORD_W-1:0]      i_run_count;
    logic [WORD_W-1:0]      i_run_delta;
    logic signed [WORD_W-1:0] i_run_offset;
    logic [WORD_W-1:0]      i_sample_index;
    logic                   o_valid;
    logic                   i_ready;
    logic [STATUS_W-1:0]    o_status;
    logic [DTS_W-1:0]       o_decode_time_us;
    logic signed [PTS_W-1:0] o_present_time_us;
    logic [DUR_W-1:0]       o_duration_us;

    sample_time_lookup_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_run_count      (i_run_count),
        .i_run_delta      (i_run_delta),
        .i_run_offset     (i_run_offset),
        .i_sample_index   (i_sample_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_decode_time_us (o_decode_time_us),
        .o_present_time_us(o_present_time_us),
        .o_duration_us    (o_duration_us)
    );

    // predictor state
    logic [31:0] ts_reg;
    logic        ctts_on;
    logic [31:0] tr_count[TABLE_DEPTH];
    logic [31:0] tr_delta[TABLE_DEPTH];
    logic [31:0] or_count[TABLE_DEPTH];
    logic [31:0] or_value[TABLE_DEPTH];
    int          time_fill;
    int          offset_fill;

    t_lookup_scoreboard sb;
    bit          long_hold;
    int          quiet_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // magnitude in ticks to microseconds, modulo 2^64
    function automatic logic [63:0] magnitude_to_us(logic [63:0] m);
        logic [63:0] ts;
        ts = {32'd0, ts_reg};
        if (ts == 0) return 64'd0;
        return (m / ts) * 64'd1000000 + ((m % ts) * 64'd1000000) / ts;
    endfunction

    // signed tick count to microseconds, truncating toward zero
    function automatic logic [63:0] ticks_to_micro(logic [63:0] t);
        if (t[63]) return 64'd0 - magnitude_to_us(64'd0 - t);
        return magnitude_to_us(t);
    endfunction

    // apply one transaction to the predictor and return its result
    function automatic t_lookup_result predict_lookup(logic [1:0] mode, logic [31:0] cnt,
            logic [31:0] dlt, logic [31:0] ofs, logic [31:0] idx);
        t_lookup_result r;
        logic [63:0] ticks, cursor, dur_ticks, off, oc, dts, pts, dur;
        r = '0;
        ticks = 0; cursor = 0; dur_ticks = 0; off = 0; oc = 0;
        case (mode)
            MODE_CLEAR: begin
                time_fill = 0;
                offset_fill = 0;
            end
            MODE_ADD_TS: begin
                if (time_fill >= TABLE_DEPTH) r.status = ST_FULL;
                else begin
                    tr_count[time_fill] = cnt;
                    tr_delta[time_fill] = dlt;
                    time_fill++;
                end
            end
            MODE_ADD_CO: begin
                if (offset_fill >= TABLE_DEPTH) r.status = ST_FULL;
                else begin
                    or_count[offset_fill] = cnt;
                    or_value[offset_fill] = ofs;
                    offset_fill++;
                end
            end
            default: begin
                if (time_fill == 0) r.status = ST_EMPTY;
                else begin
                    for (int i = 0; i < time_fill; i++) begin
                        if ({32'd0, idx} < cursor + tr_count[i]) begin
                            dur_ticks = tr_delta[i];
                            ticks += ({32'd0, idx} - cursor) * tr_delta[i];
                            break;
                        end
                        ticks += {32'd0, tr_count[i]} * {32'd0, tr_delta[i]};
                        cursor += tr_count[i];
                    end
                    dts = ticks_to_micro(ticks);
                    if (ctts_on) begin
                        for (int i = 0; i < offset_fill; i++) begin
                            if ({32'd0, idx} < oc + or_count[i]) begin
                                off = {{32{or_value[i][31]}}, or_value[i]};
                                break;
                            end
                            oc += or_count[i];
                        end
                        pts = ticks_to_micro(ticks + off);
                    end else begin
                        pts = dts;
                    end
                    dur = magnitude_to_us(dur_ticks);
                    r.decode_us  = dts[62:0];
                    r.present_us = pts;
                    r.dur_us     = dur[DUR_W-1:0];
                end
            end
        endcase
        return r;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    // write one configuration register
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TIMESCALE) ts_reg = data;
        else ctts_on = data[0];
        @(posedge i_clk);
    endtask

    // offer one transaction after a random gap, predicting at acceptance
    // valid stays up after acceptance; the next gap or drain drops it
    task automatic send_item(logic [1:0] mode, logic [31:0] cnt, logic [31:0] dlt,
            logic [31:0] ofs, logic [31:0] idx, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_valid <= 1'b0;
            idle_cycles(gap);
        end
        i_valid        <= 1'b1;
        i_mode         <= mode;
        i_run_count    <= cnt;
        i_run_delta    <= dlt;
        i_run_offset   <= ofs;
        i_sample_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(predict_lookup(mode, cnt, dlt, ofs, idx));
    endtask

    // wait for all results, then let the block settle before a register write
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        idle_cycles(20);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 4);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 2);
            2: return $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    // random query index, mostly within the current runs
    function automatic logic [31:0] rand_index();
        logic [63:0] total;
        total = 0;
        for (int i = 0; i < time_fill; i++) total += tr_count[i];
        if ($urandom_range(0, 4) == 0 || total == 0) return rand_word();
        if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
        return $urandom_range(0, total[31:0]);
    endfunction

    // one table build with random contents followed by queries
    task automatic random_table_session(int runs, int queries);
        logic [31:0] cnt;
        send_item(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
        for (int i = 0; i < runs; i++) begin
            cnt = ($urandom_range(0, 5) == 0) ? rand_word() : $urandom_range(0, 20);
            send_item(MODE_ADD_TS, cnt,
                      ($urandom_range(0, 3) == 0) ? rand_word() : $urandom_range(0, 3000),
                      $urandom, $urandom);
            if ($urandom_range(0, 1))
                send_item(MODE_ADD_CO, $urandom_range(0, 20), $urandom, rand_word(),
                          $urandom);
        end
        for (int q = 0; q < queries; q++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(2'($urandom_range(0, 2)), rand_word(), rand_word(), rand_word(),
                          $urandom);
            else
                send_item(MODE_QUERY, $urandom, $urandom, $urandom, rand_index());
        end
    endtask

    // result side: random stalls, plus one long hold-off
    initial begin
        t_lookup_result got;
        int gap;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                long_hold = 0;
            end else begin
                gap = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8) : 0;
                if (gap != 0) begin
                    i_ready <= 1'b0;
                    idle_cycles(gap);
                end
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.status     = o_status;
            got.decode_us  = o_decode_time_us;
            got.present_us = o_present_time_us;
            got.dur_us     = o_duration_us;
            sb.check_result(got);
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sample_time_lookup_unit verification failed");
            $finish;
        end
    end

    // main stimulus
    initial begin
        sb = new();
        long_hold = 0;
        ts_reg = 0; ctts_on = 0; time_fill = 0; offset_fill = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_mode = '0; i_run_count = '0; i_run_delta = '0;
        i_run_offset = '0; i_sample_index = '0;
        idle_cycles(2);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table query and timescale zero
        send_item(MODE_QUERY, 0, 0, 0, 0);
        send_item(MODE_ADD_TS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        send_item(MODE_QUERY, 0, 0, 0, 5);
        drain();
        write_reg(CFG_TIMESCALE, 32'd90000);
        write_reg(CFG_CTTS, 1);
        // extremes, past end, negative offsets, no matching offset run
        send_item(MODE_ADD_TS, 3, 3000, 0, 0);
        send_item(MODE_ADD_TS, 0, 7, 0, 0);
        send_item(MODE_ADD_CO, 2, 0, 32'h8000_0000, 0);
        send_item(MODE_ADD_CO, 1, 0, 32'h7FFF_FFFF, 0);
        send_item(MODE_QUERY, 0, 0, 0, 0);
        send_item(MODE_QUERY, 0, 0, 0, 32'hFFFF_FFFE);
        send_item(MODE_QUERY, 0, 0, 0, 32'hFFFF_FFFF);
        send_item(MODE_QUERY, 0, 0, 0, 32'hFFFF_FFFF);
        send_item(MODE_CLEAR, 0, 0, 0, 0);
        send_item(MODE_QUERY, 0, 0, 0, 1);
        send_item(MODE_ADD_TS, 2, 1, 0, 0);
        send_item(MODE_ADD_CO, 0, 0, 32'hFFFF_FFFF, 0);
        send_item(MODE_QUERY, 0, 0, 0, 0);
        send_item(MODE_QUERY, 0, 0, 0, 9);
        drain();
        write_reg(CFG_TIMESCALE, 32'hFFFF_FFFF);
        send_item(MODE_QUERY, 0, 0, 0, 1);
        drain();
        write_reg(CFG_TIMESCALE, 1);
        send_item(MODE_QUERY, 0, 0, 0, 1);

        // fill both tables past capacity
        send_item(MODE_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
            send_item(MODE_ADD_TS, $urandom_range(1, 4), $urandom_range(0, 100), 0, 0, 1);
            send_item(MODE_ADD_CO, $urandom_range(1, 4), 0, $urandom, 0, 1);
        end
        // receiver stalls long while queries keep coming
        long_hold = 1;
        for (int q = 0; q < 6; q++) send_item(MODE_QUERY, 0, 0, 0, rand_index(), 1);
        send_item(MODE_QUERY, 0, 0, 0, 32'hFFFF_FFFF);
        drain();

        // random phases across register settings
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: write_reg(CFG_TIMESCALE, $urandom_range(1, 100000));
                1: write_reg(CFG_TIMESCALE, 32'hFFFF_FFFF);
                2: write_reg(CFG_TIMESCALE, $urandom);
                default: write_reg(CFG_TIMESCALE, $urandom_range(0, 1) ? 0 : 1);
            endcase
            write_reg(CFG_CTTS, $urandom_range(0, 1));
            for (int s = 0; s < 6; s++)
                random_table_session($urandom_range(1, 6), $urandom_range(10, 20));
            drain();
        end

        drain();
        idle_cycles(2000);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("sample_time_lookup_unit verification clean");
        else
            $display("sample_time_lookup_unit verification failed");
        $finish;
    end
endmodule

// File: filelist.f
hdl/stl_pkg.sv
hdl/sample_time_lookup_unit.sv
verif/testbench.sv
